// ----- rtl/aff2d_pkg.sv -----
// Shared types, constants and arithmetic for the 2D affine transform composer.
// Depends on nothing; every other file imports it.
package aff2d_pkg;

  localparam int QW = 32;
  localparam int MagW = 17;
  localparam int MatrixSize = 3;
  localparam int NumEntries = (MatrixSize - 1) * MatrixSize;
  localparam int SineTableDepth = 1024;
  localparam int AngleW = 12;
  localparam int AngleQuarterBits = 10;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t QOne = 32'sh0001_0000;
  localparam q_t QMinusOne = -32'sh0001_0000;
  localparam q_t QMax = 32'sh7fff_ffff;
  localparam q_t QMin = 32'sh8000_0000;

  typedef enum logic [2:0] {
    OpIdentity  = 3'd0,
    OpTranslate = 3'd1,
    OpRotate    = 3'd2,
    OpScale     = 3'd3,
    OpReflect   = 3'd4,
    OpPoint     = 3'd5,
    OpAxisScale = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0]        op;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic [AngleW-1:0] angle;
    logic              flag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
  } out_item_t;

  // Sum of two products rounded half up to Q16.16, plus a Q16.16 offset,
  // saturated to 32 bits.
  function automatic q_t mac2(q_t a0, q_t b0, q_t a1, q_t b1, q_t add);
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [65:0] acc;
    logic signed [49:0] r;
    p0 = a0 * b0;
    p1 = a1 * b1;
    acc = 66'(p0) + 66'(p1) + 66'sd32768;
    r = 50'(acc >>> 16) + 50'(add);
    if (r > 50'sd2147483647) begin
      return QMax;
    end else if (r < -50'sd2147483648) begin
      return QMin;
    end
    return q_t'(r[QW-1:0]);
  endfunction

endpackage

// ----- rtl/aff2d_trig.sv -----
// Quarter-wave sine table with two registered read ports giving sine and cosine.
// Depends on aff2d_pkg; the table is built at elaboration.
module aff2d_trig import aff2d_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SineTableDepth
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AngleW-1:0] angle_i,
  output q_t                sin_o,
  output q_t                cos_o
);

  localparam int AddrW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IdxProdW = AngleQuarterBits + AddrW;

  typedef logic [MagW-1:0] rom_t [SINE_TABLE_DEPTH + 1];

  function automatic logic [63:0] next_term(logic [63:0] t, logic [63:0] x);
    logic [63:0] v;
    v = (t * x) >> 30;
    v = (v * x) >> 30;
    return v;
  endfunction

  // Taylor series in Q30, rounded half up to Q16.16.
  function automatic rom_t build_rom();
    rom_t        tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (64'(i) * HalfPiQ30) / SINE_TABLE_DEPTH;
      term = x;
      sum = x;
      term = next_term(term, x) / 64'd6;   sum = sum - term;
      term = next_term(term, x) / 64'd20;  sum = sum + term;
      term = next_term(term, x) / 64'd42;  sum = sum - term;
      term = next_term(term, x) / 64'd72;  sum = sum + term;
      term = next_term(term, x) / 64'd110; sum = sum - term;
      term = next_term(term, x) / 64'd156; sum = sum + term;
      term = next_term(term, x) / 64'd210; sum = sum - term;
      term = next_term(term, x) / 64'd272; sum = sum + term;
      term = next_term(term, x) / 64'd342; sum = sum - term;
      term = next_term(term, x) / 64'd420; sum = sum + term;
      r = (sum + 64'd8192) >> 14;
      if (r > 64'd65536) begin
        r = 64'd65536;
      end
      tab[i] = MagW'(r);
    end
    return tab;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [1:0]          s_quad;
  logic [1:0]          c_quad;
  logic [IdxProdW-1:0] idx_prod;
  logic [AddrW-1:0]    idx;
  logic [AddrW-1:0]    s_addr;
  logic [AddrW-1:0]    c_addr;
  logic [MagW-1:0]     s_mag_q;
  logic [MagW-1:0]     c_mag_q;
  logic                s_neg_q;
  logic                c_neg_q;

  // The cosine shares the table index and sits one quadrant ahead.
  always_comb begin
    s_quad = angle_i[AngleW-1:AngleQuarterBits];
    c_quad = s_quad + 2'd1;
    idx_prod = IdxProdW'(angle_i[AngleQuarterBits-1:0]) * IdxProdW'(SINE_TABLE_DEPTH);
    idx = AddrW'(idx_prod >> AngleQuarterBits);
    s_addr = s_quad[0] ? AddrW'(SINE_TABLE_DEPTH) - idx : idx;
    c_addr = c_quad[0] ? AddrW'(SINE_TABLE_DEPTH) - idx : idx;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      s_mag_q <= SineRom[s_addr];
      c_mag_q <= SineRom[c_addr];
      s_neg_q <= s_quad[1];
      c_neg_q <= c_quad[1];
    end
  end

  assign sin_o = s_neg_q ? -q_t'(s_mag_q) : q_t'(s_mag_q);
  assign cos_o = c_neg_q ? -q_t'(c_mag_q) : q_t'(c_mag_q);

endmodule

// ----- rtl/aff2d_datapath.sv -----
// Transform matrix registers, elementary matrix build, premultiply and point mapping.
// Depends on aff2d_pkg for the item types and the saturating multiply-add.
module aff2d_datapath import aff2d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  in_item_t  item_i,
  input  q_t        sin_i,
  input  q_t        cos_i,
  output out_item_t point_o
);

  q_t   m_q [NumEntries];
  q_t   m_d [NumEntries];
  q_t   r   [NumEntries];
  q_t   n   [NumEntries];
  q_t   vx;
  q_t   vy;
  logic is_update;

  assign vx = item_i.value_x;
  assign vy = item_i.value_y;

  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      r[i] = '0;
    end
    r[0] = QOne;
    r[MatrixSize + 1] = QOne;
    is_update = 1'b1;
    case (item_i.op)
      OpTranslate: begin
        r[2] = vx;
        r[MatrixSize + 2] = vy;
      end
      OpRotate: begin
        r[0] = cos_i;
        r[MatrixSize + 1] = cos_i;
        r[1] = item_i.flag ? -sin_i : sin_i;
        r[MatrixSize] = item_i.flag ? sin_i : -sin_i;
      end
      OpScale: begin
        r[0] = vx;
        r[MatrixSize + 1] = vx;
      end
      OpReflect: begin
        if (!item_i.flag) begin
          r[0] = QMinusOne;
          r[2] = vx;
        end else begin
          r[MatrixSize + 1] = QMinusOne;
          r[MatrixSize + 2] = vy;
        end
      end
      OpAxisScale: begin
        if (!item_i.flag) begin
          r[0] = vx;
        end else begin
          r[MatrixSize + 1] = vx;
        end
      end
      default: begin
        is_update = 1'b0;
      end
    endcase
  end

  // New transform is R*T; only the offset column picks up R's translation.
  always_comb begin
    for (int row = 0; row < MatrixSize - 1; row++) begin
      n[row*MatrixSize]     = mac2(r[row*MatrixSize], m_q[0], r[row*MatrixSize+1],
                                   m_q[MatrixSize], '0);
      n[row*MatrixSize + 1] = mac2(r[row*MatrixSize], m_q[1], r[row*MatrixSize+1],
                                   m_q[MatrixSize+1], '0);
      n[row*MatrixSize + 2] = mac2(r[row*MatrixSize], m_q[2], r[row*MatrixSize+1],
                                   m_q[MatrixSize+2], r[row*MatrixSize+2]);
    end
  end

  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      m_d[i] = m_q[i];
    end
    if (advance_i) begin
      if (item_i.op == OpIdentity) begin
        for (int i = 0; i < NumEntries; i++) begin
          m_d[i] = '0;
        end
        m_d[0] = QOne;
        m_d[MatrixSize + 1] = QOne;
      end else if (is_update) begin
        for (int i = 0; i < NumEntries; i++) begin
          m_d[i] = n[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEntries; i++) begin
        m_q[i] <= '0;
      end
      m_q[0] <= QOne;
      m_q[MatrixSize + 1] <= QOne;
    end else begin
      for (int i = 0; i < NumEntries; i++) begin
        m_q[i] <= m_d[i];
      end
    end
  end

  assign point_o.out_x = mac2(m_q[0], vx, m_q[1], vy, m_q[2]);
  assign point_o.out_y = mac2(m_q[MatrixSize], vx, m_q[MatrixSize+1], vy,
                              m_q[MatrixSize+2]);

  a_identity_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.op == OpIdentity |=>
      m_q[0] == QOne && m_q[MatrixSize+1] == QOne && m_q[1] == '0 && m_q[2] == '0)
    else $error("transform not identity after identity beat");

  a_point_keeps_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.op == OpPoint |=>
      $stable(m_q[0]) && $stable(m_q[2]) && $stable(m_q[MatrixSize+1]))
    else $error("point beat changed the transform");

endmodule

// ----- rtl/affine_2d_transform_composer_top.sv -----
// An accepted point beat waits in a_item_q for a free result register, then lands in out_item_q.
// Throughput: one beat per cycle; only a point beat waits, and only on a held result.
// Transform registers take R*T on an advancing update beat; an identity beat loads the identity.
// Sine and cosine come from a registered two-port table read at the accepting edge.
// Reset: asynchronous, active low; clears the stages and loads the identity transform.
module affine_2d_transform_composer_top import aff2d_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SineTableDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_accept;
  logic      a_valid_q;
  logic      a_valid_d;
  in_item_t  a_item_q;
  logic      a_is_point;
  logic      out_free;
  logic      advance;
  logic      out_valid_q;
  logic      out_valid_d;
  out_item_t out_item_q;
  out_item_t point;
  q_t        sin_val;
  q_t        cos_val;

  assign a_is_point = a_item_q.op == OpPoint;
  assign out_free = !out_valid_q || !out_stall_i;
  // Update beats never wait; a point beat waits for room in the result register.
  assign advance = a_valid_q && (!a_is_point || out_free);
  assign in_stall_o = a_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  assign a_valid_d = in_accept || (a_valid_q && !advance);
  assign out_valid_d = (advance && a_is_point) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_item_q <= in_item_i;
    end
    if (advance && a_is_point) begin
      out_item_q <= point;
    end
  end

  aff2d_trig #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_trig (
    .clk_i   (clk_i),
    .rd_en_i (in_accept),
    .angle_i (in_item_i.angle),
    .sin_o   (sin_val),
    .cos_o   (cos_val)
  );

  aff2d_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (a_item_q),
    .sin_i     (sin_val),
    .cos_i     (cos_val),
    .point_o   (point)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

  a_point_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && a_is_point |=> out_valid_q)
    else $error("point beat moved on but no result was registered");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> a_valid_q && a_is_point && out_valid_q)
    else $error("input stalled without a blocked point beat");

  a_update_never_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_is_point |-> advance)
    else $error("update beat held in the input register");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the 2D affine transform composer: directed beats, then random
// update and point sequences, scored by an in-bench Q16.16 predictor or pinned results.
// Depends on aff2d_pkg and affine_2d_transform_composer_top.
module tb_top;
  import aff2d_pkg::*;

  localparam logic [2:0] OpUnused = 3'd7;
  localparam int RandomItems = 1325;
  localparam int HoldAt = 400;
  localparam int DrainAt = 800;
  localparam int SteadyTail = 200;
  localparam int LongHold = 300;

  typedef struct {
    in_item_t  beat;
    logic      pinned;
    out_item_t pinned_pt;
  } plan_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Expected point results, oldest first.
  out_item_t pending_points [$];
  q_t        xf [6] = '{QOne, 32'sd0, 32'sd0, 32'sd0, QOne, 32'sd0};
  logic      pin_valid;
  out_item_t pin_point;
  logic      hold_req;
  logic      steady;
  int        mismatches;

  affine_2d_transform_composer_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Exact sum of two products, rounded half up to Q16.16, plus an offset, then clipped.
  function automatic q_t q_mul_add(q_t a0, q_t b0, q_t a1, q_t b1, q_t offs);
    logic signed [65:0] w0, w1, w2, w3, total;
    w0 = a0;
    w1 = b0;
    w2 = a1;
    w3 = b1;
    total = w0 * w1 + w2 * w3 + 66'sd32768;
    total = (total >>> 16) + offs;
    if (total > 66'sd2147483647) begin
      return QMax;
    end
    if (total < -66'sd2147483648) begin
      return QMin;
    end
    return total[31:0];
  endfunction

  // One quarter-wave entry: Taylor series in Q30, rounded to Q16.16.
  function automatic q_t quarter_wave_q(int unsigned i);
    logic [63:0] x, term, acc, r;
    int unsigned k;
    x = (64'(i) * HalfPiQ30) / 64'(SineTableDepth);
    term = x;
    acc = x;
    for (k = 1; k <= 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    r = (acc + 64'd8192) >> 14;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    return r[31:0];
  endfunction

  function automatic q_t sine_q(logic [AngleW-1:0] a);
    logic [1:0] quad;
    int unsigned idx;
    q_t mag;
    quad = a[AngleW-1:AngleQuarterBits];
    idx = (int'(a[AngleQuarterBits-1:0]) * SineTableDepth) >> AngleQuarterBits;
    if (idx >= SineTableDepth) begin
      idx = SineTableDepth - 1;
    end
    mag = quad[0] ? quarter_wave_q(SineTableDepth - idx) : quarter_wave_q(idx);
    return quad[1] ? -mag : mag;
  endfunction

  // Folds one accepted beat into the running transform; a point beat yields its image.
  function automatic void compose_and_map(input in_item_t beat, output logic makes_point,
                                          output out_item_t pt);
    q_t rm [6];
    q_t nx [6];
    q_t s, c;
    logic [AngleW-1:0] cos_angle;
    logic composes;
    int rw;
    rm = '{QOne, 32'sd0, 32'sd0, 32'sd0, QOne, 32'sd0};
    composes = 1'b1;
    makes_point = 1'b0;
    pt = '0;
    case (beat.op)
      OpIdentity: begin
        xf = '{QOne, 32'sd0, 32'sd0, 32'sd0, QOne, 32'sd0};
        composes = 1'b0;
      end
      OpTranslate: begin
        rm[2] = beat.value_x;
        rm[5] = beat.value_y;
      end
      OpRotate: begin
        cos_angle = beat.angle + 12'd1024;
        s = sine_q(beat.angle);
        c = sine_q(cos_angle);
        rm[0] = c;
        rm[4] = c;
        rm[1] = beat.flag ? -s : s;
        rm[3] = beat.flag ? s : -s;
      end
      OpScale: begin
        rm[0] = beat.value_x;
        rm[4] = beat.value_x;
      end
      OpReflect: begin
        if (!beat.flag) begin
          rm[0] = QMinusOne;
          rm[2] = beat.value_x;
        end else begin
          rm[4] = QMinusOne;
          rm[5] = beat.value_y;
        end
      end
      OpPoint: begin
        pt.out_x = q_mul_add(xf[0], beat.value_x, xf[1], beat.value_y, xf[2]);
        pt.out_y = q_mul_add(xf[3], beat.value_x, xf[4], beat.value_y, xf[5]);
        makes_point = 1'b1;
        composes = 1'b0;
      end
      OpAxisScale: begin
        if (!beat.flag) begin
          rm[0] = beat.value_x;
        end else begin
          rm[4] = beat.value_x;
        end
      end
      default: begin
        composes = 1'b0;
      end
    endcase
    if (composes) begin
      // The new elementary matrix acts after everything composed so far: T := R * T.
      for (rw = 0; rw < 2; rw++) begin
        nx[3*rw]   = q_mul_add(rm[3*rw], xf[0], rm[3*rw+1], xf[3], 32'sd0);
        nx[3*rw+1] = q_mul_add(rm[3*rw], xf[1], rm[3*rw+1], xf[4], 32'sd0);
        nx[3*rw+2] = q_mul_add(rm[3*rw], xf[2], rm[3*rw+1], xf[5], rm[3*rw+2]);
      end
      xf = nx;
    end
  endfunction

  task automatic note_mismatch(input string what, input q_t got, input q_t want);
    mismatches++;
    $display("%0t ns: %s got %h expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    logic makes_point;
    if (rst_n && in_valid && !in_stall) begin
      compose_and_map(in_item, makes_point, want);
      if (makes_point) begin
        pending_points.push_back(pin_valid ? pin_point : want);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        note_mismatch("result beat with nothing pending, out_x", out_item.out_x, '0);
      end else begin
        want = pending_points.pop_front();
        if (out_item.out_x !== want.out_x) begin
          note_mismatch("out_x", out_item.out_x, want.out_x);
        end
        if (out_item.out_y !== want.out_y) begin
          note_mismatch("out_y", out_item.out_y, want.out_y);
        end
      end
    end
  end

  // Result side: random stall bursts, one long hold on request, none in the steady tail.
  initial begin : receiver
    int unsigned left;
    out_stall = 1'b0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LongHold) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
        left = 0;
      end else if (steady) begin
        out_stall = 1'b0;
      end else if (left == 0) begin
        out_stall = ($urandom_range(0, 2) == 0);
        left = $urandom_range(0, 14);
      end else begin
        left--;
      end
    end
  end

  initial begin
    #1_600_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic offer(input in_item_t beat, input logic pinned, input out_item_t pinned_pt);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_item = beat;
    pin_valid = pinned;
    pin_point = pinned_pt;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic plan_row_t step_row(logic [2:0] op, q_t vx, q_t vy,
                                         logic [AngleW-1:0] ang, logic fl,
                                         logic pin, q_t px, q_t py);
    plan_row_t pr;
    pr.beat.op = op;
    pr.beat.value_x = vx;
    pr.beat.value_y = vy;
    pr.beat.angle = ang;
    pr.beat.flag = fl;
    pr.pinned = pin;
    pr.pinned_pt.out_x = px;
    pr.pinned_pt.out_y = py;
    return pr;
  endfunction

  function automatic q_t rand_q();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return QMax;
          1: return QMin;
          2: return QOne;
          3: return QMinusOne;
          default: return 32'sd0;
        endcase
      end
      default: return q_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // Scale factors mostly between one half and two, either sign, so products stay in range.
  function automatic q_t scale_factor();
    q_t mag;
    if ($urandom_range(0, 15) == 0) begin
      return rand_q();
    end
    mag = q_t'($urandom_range(32'h0000_8000, 32'h0002_0000));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic in_item_t noise_beat();
    in_item_t b;
    b.op = 3'($urandom_range(0, 7));
    b.value_x = $urandom;
    b.value_y = $urandom;
    b.angle = AngleW'($urandom_range(0, 4095));
    b.flag = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic in_item_t update_beat();
    in_item_t b;
    b = noise_beat();
    case ($urandom_range(0, 4))
      0: begin
        b.op = OpTranslate;
        b.value_x = rand_q();
        b.value_y = rand_q();
      end
      1: b.op = OpRotate;
      2: begin
        b.op = OpScale;
        b.value_x = scale_factor();
      end
      3: begin
        b.op = OpReflect;
        b.value_x = rand_q();
        b.value_y = rand_q();
      end
      default: begin
        b.op = OpAxisScale;
        b.value_x = scale_factor();
      end
    endcase
    return b;
  endfunction

  initial begin : stimulus
    plan_row_t plan [$];
    in_item_t burst_q [$];
    in_item_t b;
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    pin_valid = 1'b0;
    pin_point = '0;
    hold_req = 1'b0;
    steady = 1'b0;
    mismatches = 0;
    sent = 0;

    // Rows with a typed-in result can be read straight off the matrix; the rest
    // go through the predictor.
    plan = '{
      step_row(OpPoint, 32'sh0003_8000, -32'sh0002_4000, 0, 0,
               1, 32'sh0003_8000, -32'sh0002_4000),
      step_row(OpPoint, QMax, QMin, 4095, 1, 1, QMax, QMin),
      step_row(OpUnused, QMin, QMax, 1024, 1, 0, 0, 0),
      step_row(OpPoint, 0, 0, 0, 0, 1, 0, 0),
      step_row(OpTranslate, QMax, QMax, 0, 0, 0, 0, 0),
      step_row(OpPoint, QMax, 0, 0, 0, 1, QMax, QMax),
      step_row(OpPoint, QMin, QMin, 0, 0, 1, -32'sd1, -32'sd1),
      step_row(OpIdentity, QMax, QMin, 4095, 1, 0, 0, 0),
      step_row(OpRotate, 0, 0, 1024, 1, 0, 0, 0),
      step_row(OpPoint, QOne, 0, 0, 0, 0, 0, 0),
      step_row(OpRotate, 0, 0, 4095, 0, 0, 0, 0),
      step_row(OpRotate, 0, 0, 0, 1, 0, 0, 0),
      step_row(OpRotate, 0, 0, 3072, 0, 0, 0, 0),
      step_row(OpRotate, 0, 0, 2048, 1, 0, 0, 0),
      step_row(OpPoint, QOne, -32'sh0002_0000, 0, 0, 0, 0, 0),
      step_row(OpIdentity, 0, 0, 0, 0, 0, 0, 0),
      step_row(OpScale, QMin, 0, 0, 0, 0, 0, 0),
      step_row(OpPoint, QMin, QMax, 0, 0, 0, 0, 0),
      step_row(OpIdentity, 0, 0, 0, 0, 0, 0, 0),
      step_row(OpAxisScale, 32'sh0002_0000, 0, 0, 0, 0, 0, 0),
      step_row(OpAxisScale, -32'sh0000_8000, 0, 0, 1, 0, 0, 0),
      step_row(OpReflect, 32'sh000a_0000, 32'sh0005_0000, 0, 0, 0, 0, 0),
      step_row(OpReflect, 32'sh0007_0000, -32'sh0003_0000, 0, 1, 0, 0, 0),
      step_row(OpPoint, 32'sh0001_8000, 32'sh0002_8000, 0, 0, 0, 0, 0),
      step_row(OpScale, QMax, 0, 0, 0, 0, 0, 0),
      step_row(OpPoint, QMax, QMin, 0, 0, 0, 0, 0),
      step_row(OpIdentity, 0, 0, 0, 0, 0, 0, 0)
    };

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[k]) begin
      offer(plan[k].beat, plan[k].pinned, plan[k].pinned_pt);
    end

    // Mostly well-formed sequences: optional identity, a few updates, then points.
    while (sent < RandomItems) begin
      burst_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) burst_q.push_back(noise_beat());
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          b = noise_beat();
          b.op = OpIdentity;
          burst_q.push_back(b);
        end
        repeat ($urandom_range(1, 4)) burst_q.push_back(update_beat());
        repeat ($urandom_range(1, 6)) begin
          b = noise_beat();
          b.op = OpPoint;
          b.value_x = rand_q();
          b.value_y = rand_q();
          burst_q.push_back(b);
        end
      end
      foreach (burst_q[k]) begin
        offer(burst_q[k], 1'b0, '0);
        if (burst_q[k].op != OpUnused) begin
          sent++;
          if (sent == HoldAt) begin
            hold_req = 1'b1;
          end
          if (sent == DrainAt) begin
            in_valid = 1'b0;
            do @(negedge clk); while (pending_points.size() != 0);
          end
          if (sent == RandomItems - SteadyTail) begin
            steady = 1'b1;
          end
        end
      end
    end

    in_valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/aff2d_pkg.sv
rtl/aff2d_trig.sv
rtl/aff2d_datapath.sv
rtl/affine_2d_transform_composer_top.sv
verif/tb_top.sv
